FILE: rtl/glu_pkg.sv
`default_nettype none

package glu_pkg;

    localparam int GLU_OPERAND_WIDTH = 32;
    localparam int GLU_FIELD_WIDTH   = 32;
    localparam int GLU_GCD_WIDTH     = 31;
    localparam int GLU_LCM_WIDTH     = 62;
    localparam int GLU_PC_WIDTH      = 4;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic signed [GLU_FIELD_WIDTH-1:0] first_operand;
        logic signed [GLU_FIELD_WIDTH-1:0] second_operand;
    } glu_in_t;

    typedef struct packed {
        logic [GLU_GCD_WIDTH-1:0] gcd_value;
        logic [GLU_LCM_WIDTH-1:0] lcm_value;
        logic                     status;
    } glu_out_t;

    // Divider control between sequencer and divider
    typedef struct packed {
        logic load;
        logic step;
    } glu_div_ctrl_t;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_ORDER    = 3'd1,
        OP_DIV_MOD  = 3'd2,
        OP_DIV_QUO  = 3'd3,
        OP_DIV_STEP = 3'd4,
        OP_ROTATE   = 3'd5,
        OP_MULTIPLY = 3'd6,
        OP_EMIT     = 3'd7
    } glu_op_t;

    typedef enum logic [2:0] {
        COND_NEVER      = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_INVALID    = 3'd2,
        COND_SMALL_ZERO = 3'd3,
        COND_DIV_MORE   = 3'd4
    } glu_cond_t;

    typedef struct packed {
        glu_op_t                 op;
        glu_cond_t               cond;
        logic [GLU_PC_WIDTH-1:0] target;
    } glu_ucode_t;

    localparam logic [GLU_PC_WIDTH-1:0] PC_LOOP     = 4'd1;
    localparam logic [GLU_PC_WIDTH-1:0] PC_MOD_STEP = 4'd3;
    localparam logic [GLU_PC_WIDTH-1:0] PC_GCD_DONE = 4'd5;
    localparam logic [GLU_PC_WIDTH-1:0] PC_QUO_STEP = 4'd6;
    localparam logic [GLU_PC_WIDTH-1:0] PC_EMIT     = 4'd8;

    // Microcode program: Euclid loop, then a / gcd, then multiply by b
    function automatic glu_ucode_t glu_ucode(input logic [GLU_PC_WIDTH-1:0] pc);
        glu_ucode_t uc;
        uc = '{op: OP_NOP, cond: COND_NEVER, target: '0};
        case (pc)
            4'd0: uc = '{op: OP_ORDER,    cond: COND_INVALID,    target: PC_EMIT};
            4'd1: uc = '{op: OP_NOP,      cond: COND_SMALL_ZERO, target: PC_GCD_DONE};
            4'd2: uc = '{op: OP_DIV_MOD,  cond: COND_NEVER,      target: '0};
            4'd3: uc = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,   target: PC_MOD_STEP};
            4'd4: uc = '{op: OP_ROTATE,   cond: COND_ALWAYS,     target: PC_LOOP};
            4'd5: uc = '{op: OP_DIV_QUO,  cond: COND_NEVER,      target: '0};
            4'd6: uc = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,   target: PC_QUO_STEP};
            4'd7: uc = '{op: OP_MULTIPLY, cond: COND_NEVER,      target: '0};
            4'd8: uc = '{op: OP_EMIT,     cond: COND_NEVER,      target: '0};
            default: uc = '{op: OP_EMIT,  cond: COND_NEVER,      target: '0};
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/glu_div.sv
`default_nettype none

module glu_div
    import glu_pkg::*;
#(
    parameter int WIDTH = GLU_OPERAND_WIDTH - 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire glu_div_ctrl_t    ctrl,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  more,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   trial;
    logic             fits;

    // Restoring division, one quotient bit per step
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (ctrl.load)
        begin
            cnt_next = CW'(WIDTH);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (ctrl.step)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? WIDTH'(trial - {1'b0, dvs_reg}) : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign more      = cnt_reg > CW'(1);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/gcd_lcm_unit_top.sv
`default_nettype none

// Channel   Ports                 Handshake              Beat
// --------  --------------------  ---------------------  ----------------------------
// command   start, busy, operands start high, busy low   glu_in_t: two signed operands
// result    done, result          done high, one cycle   glu_out_t: gcd, lcm, status
//
// Busy stays high from the accepted command until the result beat; an invalid
// operand pair skips the Euclid loop. The divider, one quotient bit per cycle
// while stepping, is shared by every modulo step and by the final a / gcd. done
// rises at the same edge at which busy falls, and a new command beat may be taken
// in the cycle that shows the result beat.
// Reset: rst_n clears the sequencer, busy and done at once; no clearing pass.
// Stalls: the receiver cannot stall; each result beat is shown for one cycle only.

module gcd_lcm_unit_top
    import glu_pkg::*;
#(
    parameter int OPERAND_WIDTH = GLU_OPERAND_WIDTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire glu_in_t operands,
    output logic         done,
    output glu_out_t     result
);

    // Magnitude width of a valid (positive) operand
    localparam int MAG = OPERAND_WIDTH - 1;
    localparam int PW  = 2 * MAG;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [GLU_PC_WIDTH-1:0] pc_reg, pc_next;
    logic                    invalid_reg, invalid_next;
    logic [MAG-1:0]          oa_reg, oa_next;
    logic [MAG-1:0]          ob_reg, ob_next;
    logic [MAG-1:0]          big_reg, big_next;
    logic [MAG-1:0]          small_reg, small_next;
    logic [PW-1:0]           prod_reg, prod_next;
    glu_out_t                result_reg, result_next;

    logic [OPERAND_WIDTH-1:0] raw_a, raw_b;
    logic                     bad_a, bad_b;
    logic                     accept;
    glu_ucode_t               uc;
    logic                     jump;
    glu_div_ctrl_t            div_ctrl;
    logic [MAG-1:0]           div_dividend, div_divisor;
    logic                     div_more;
    logic [MAG-1:0]           div_quo, div_rem;
    logic [PW-1:0]            product;

    assign accept = start && !busy_reg;

    // Keep the low OPERAND_WIDTH bits; zero or sign bit set means invalid
    assign raw_a = operands.first_operand[OPERAND_WIDTH-1:0];
    assign raw_b = operands.second_operand[OPERAND_WIDTH-1:0];
    assign bad_a = (raw_a == '0) || raw_a[OPERAND_WIDTH-1];
    assign bad_b = (raw_b == '0) || raw_b[OPERAND_WIDTH-1];

    // Fetch the control word for the current step
    assign uc = glu_ucode(pc_reg);

    always_comb
    begin
        case (uc.cond)
            COND_ALWAYS:     jump = 1'b1;
            COND_INVALID:    jump = invalid_reg;
            COND_SMALL_ZERO: jump = (small_reg == '0);
            COND_DIV_MORE:   jump = div_more;
            default:         jump = 1'b0;
        endcase
    end

    assign product = PW'(div_quo) * PW'(ob_reg);

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        pc_next      = pc_reg;
        invalid_next = invalid_reg;
        oa_next      = oa_reg;
        ob_next      = ob_reg;
        big_next     = big_reg;
        small_next   = small_reg;
        prod_next    = prod_reg;
        result_next  = result_reg;
        div_ctrl     = '{load: 1'b0, step: 1'b0};
        div_dividend = big_reg;
        div_divisor  = small_reg;

        if (accept)
        begin
            // Latch the command beat and start the program
            busy_next    = 1'b1;
            pc_next      = '0;
            invalid_next = bad_a || bad_b;
            oa_next      = raw_a[MAG-1:0];
            ob_next      = raw_b[MAG-1:0];
        end
        else if (busy_reg)
        begin
            pc_next = jump ? uc.target : pc_reg + 1'b1;
            unique case (uc.op)
                OP_NOP:
                begin
                end
                OP_ORDER:
                begin
                    big_next   = (oa_reg >= ob_reg) ? oa_reg : ob_reg;
                    small_next = (oa_reg >= ob_reg) ? ob_reg : oa_reg;
                end
                OP_DIV_MOD:
                begin
                    div_ctrl.load = 1'b1;
                end
                OP_DIV_QUO:
                begin
                    // big holds the gcd from here on
                    div_ctrl.load = 1'b1;
                    div_dividend  = oa_reg;
                    div_divisor   = big_reg;
                end
                OP_DIV_STEP:
                begin
                    div_ctrl.step = 1'b1;
                end
                OP_ROTATE:
                begin
                    big_next   = small_reg;
                    small_next = div_rem;
                end
                OP_MULTIPLY:
                begin
                    prod_next = product;
                end
                OP_EMIT:
                begin
                    // Drop busy and present the result beat for one cycle
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    if (invalid_reg)
                    begin
                        result_next = '{gcd_value: '0, lcm_value: '0, status: STATUS_INVALID};
                    end
                    else
                    begin
                        result_next.gcd_value = GLU_GCD_WIDTH'(big_reg);
                        result_next.lcm_value = GLU_LCM_WIDTH'(prod_reg);
                        result_next.status    = STATUS_OK;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    glu_div #(
        .WIDTH(MAG)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .more     (div_more),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            pc_reg      <= '0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            pc_reg      <= pc_next;
            invalid_reg <= invalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oa_reg     <= oa_next;
        ob_reg     <= ob_next;
        big_reg    <= big_next;
        small_reg  <= small_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // A result beat never overlaps a running program
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted command always starts the program at its first step
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && pc_reg == '0))
        else $error("accepted command did not start program");

    // Invalid status carries zero values
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_INVALID) |->
            (result.gcd_value == '0 && result.lcm_value == '0))
        else $error("invalid result with nonzero values");

    // A valid result has a nonzero divisor and multiple
    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_OK) |->
            (result.gcd_value != '0 && result.lcm_value != '0))
        else $error("valid result with zero value");

endmodule

`default_nettype wire

FILE: bench/gcd_lcm_checker.sv
module gcd_lcm_checker
    import glu_pkg::*;
#(
    parameter int OPND_W = GLU_OPERAND_WIDTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     busy,
    input  wire glu_in_t  operands,
    input  wire logic     done,
    input  wire glu_out_t result,
    output int            mismatches,
    output int            outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   SHOWN_LIMIT    = 10;

    glu_out_t expected_results[$];
    int       n_bad = 0;

    // Only the low OPND_W bits count; a pair is valid when both are positive there.
    function automatic glu_out_t predict_gcd_lcm(input glu_in_t beat);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] hi_v;
        logic [63:0] lo_v;
        logic [63:0] rem_v;
        glu_out_t    res;
        a = 64'(beat.first_operand[OPND_W-1:0]);
        b = 64'(beat.second_operand[OPND_W-1:0]);
        res = '0;
        res.status = STATUS_INVALID;
        if (a != 0 && !a[OPND_W-1] && b != 0 && !b[OPND_W-1])
        begin
            hi_v = (a >= b) ? a : b;
            lo_v = (a >= b) ? b : a;
            while (lo_v != 0)
            begin
                rem_v = hi_v % lo_v;
                hi_v  = lo_v;
                lo_v  = rem_v;
            end
            res.gcd_value = hi_v[GLU_GCD_WIDTH-1:0];
            res.lcm_value = GLU_LCM_WIDTH'((a / hi_v) * b);
            res.status    = STATUS_OK;
        end
        return res;
    endfunction

    function automatic void log_failure(input string what);
        if (n_bad < SHOWN_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        n_bad++;
    endfunction

    // Retire the result first: done and the next command beat can share an edge.
    always @(posedge clk)
    begin
        glu_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    log_failure($sformatf("unexpected result gcd=%0d lcm=%0d status=%0b",
                                          result.gcd_value, result.lcm_value, result.status));
                else
                begin
                    want = expected_results.pop_front();
                    if (result.gcd_value !== want.gcd_value)
                        log_failure($sformatf("gcd_value expected %0d got %0d",
                                              want.gcd_value, result.gcd_value));
                    if (result.lcm_value !== want.lcm_value)
                        log_failure($sformatf("lcm_value expected %0d got %0d",
                                              want.lcm_value, result.lcm_value));
                    if (result.status !== want.status)
                        log_failure($sformatf("status expected %0b got %0b",
                                              want.status, result.status));
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_gcd_lcm(operands));
        end
        mismatches  <= n_bad;
        outstanding <= expected_results.size();
    end

endmodule

FILE: bench/tb_gcd_lcm_unit_top.sv
module tb_gcd_lcm_unit_top;

    timeunit 1ns;
    timeprecision 1ps;

    import glu_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int MAX_GAP      = 11;
    localparam int SETTLE       = 64;

    // Every input gets a known value from time zero; reset is held low at start.
    logic     clk      = 1'b0;
    logic     rst_n    = 1'b0;
    logic     start    = 1'b0;
    glu_in_t  operands = '0;
    logic     busy;
    logic     done;
    glu_out_t result;

    int mismatches;
    int outstanding;

    // Count of beats left in the current back-to-back burst.
    int burst_left = 0;

    always #1 clk = ~clk;

    gcd_lcm_unit_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    // The checker sits beside the block and sees exactly what the ports see.
    gcd_lcm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operands    (operands),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Draw the idle gap after a beat. Mostly random 0..MAX_GAP, but now and then
    // run a burst of zero gaps so the block sees commands arrive back to back.
    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst_left = $urandom_range(8, 40);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Hold start and the beat until the block takes it (start high, busy low at
    // an edge), then idle for the drawn gap. With a zero gap start stays high and
    // the next call only swaps the beat, so start never sees two writes in a step.
    task automatic send_pair(input glu_in_t beat);
        int gap;
        start    <= 1'b1;
        operands <= beat;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and hold off until every predicted result has come back. The
    // first edge lets the checker count the beat that was just taken.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic glu_in_t pack_pair(input logic [31:0] a, input logic [31:0] b);
        glu_in_t beat;
        beat.first_operand  = a;
        beat.second_operand = b;
        return beat;
    endfunction

    // A positive operand of random magnitude: pick a width first so small and
    // large values both show up, which also keeps the Euclid loops short on average.
    function automatic logic [31:0] positive_operand();
        int          w;
        logic [31:0] v;
        w = $urandom_range(1, 31);
        v = $urandom & ((32'd1 << w) - 32'd1);
        if (v == 0)
            v = 32'd1;
        return v;
    endfunction

    // A non-positive operand: zero, a random negative value, or the most negative.
    function automatic logic [31:0] nonpositive_operand();
        case ($urandom_range(0, 2))
            0:       return 32'd0;
            1:       return $urandom | 32'h8000_0000;
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic glu_in_t random_pair();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] g;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            // Invalid pair: one or both operands zero or negative.
            a = $urandom_range(0, 1) ? nonpositive_operand() : positive_operand();
            b = nonpositive_operand();
            if ($urandom_range(0, 1))
                return pack_pair(b, a);
            return pack_pair(a, b);
        end
        else if (pick < 42)
        begin
            // Build a common factor so the divisor is at least g, drawn from 1 to 65535.
            g = $urandom_range(1, 65535);
            a = g * $urandom_range(1, 32767);
            b = g * $urandom_range(1, 32767);
        end
        else if (pick < 82)
        begin
            a = positive_operand();
            b = positive_operand();
        end
        else
        begin
            // Full 31-bit magnitudes exercise the widest products.
            a = {1'b0, 31'($urandom)};
            b = {1'b0, 31'($urandom)};
            if (a == 0)
                a = 32'd1;
            if (b == 0)
                b = 32'd1;
        end
        if ($urandom_range(0, 19) == 0)
            b = a;
        return pack_pair(a, b);
    endfunction

    // Directed corners: zero and negative operands, the signed extremes, equal
    // operands, ones, coprime and power-of-two pairs, and the consecutive
    // Fibonacci pair that drives Euclid through its longest chain.
    glu_in_t corner_pairs[] = '{
        pack_pair(32'd0,          32'd0),
        pack_pair(32'd0,          32'd5),
        pack_pair(32'd7,          32'd0),
        pack_pair(32'hFFFF_FFFF,  32'd5),
        pack_pair(32'd9,          32'hFFFF_FFFF),
        pack_pair(32'h8000_0000,  32'h7FFF_FFFF),
        pack_pair(32'h7FFF_FFFF,  32'h8000_0000),
        pack_pair(32'h8000_0000,  32'h8000_0000),
        pack_pair(32'd1,          32'd1),
        pack_pair(32'd1,          32'h7FFF_FFFF),
        pack_pair(32'h7FFF_FFFF,  32'h7FFF_FFFF),
        pack_pair(32'h7FFF_FFFF,  32'h7FFF_FFFE),
        pack_pair(32'd12345,      32'd12345),
        pack_pair(32'd1836311903, 32'd1134903170),
        pack_pair(32'h4000_0000,  32'h2000_0000),
        pack_pair(32'd48,         32'd18),
        pack_pair(32'd18,         32'd48),
        pack_pair(32'h5555_5555,  32'h2AAA_AAAA)
    };

    // Stimulus: reset, directed corners, a full drain, then the random run with a
    // drain every 400 beats, and finally the verdict.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_pairs[i])
            send_pair(corner_pairs[i]);
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_pair(random_pair());
            if (i % 400 == 399)
                drain_results();
        end

        drain_results();
        // Hold a little longer so a stray extra done would still be caught.
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("PASS gcd_lcm_unit_top");
        else
            $display("FAIL gcd_lcm_unit_top");
        $finish;
    end

    // Watchdog: well beyond the slowest correct run, even with every pair at the
    // longest Euclid chain and every gap at its maximum.
    initial
    begin
        #30_000_000;
        $display("FAIL gcd_lcm_unit_top");
        $finish;
    end

endmodule

FILE: files.f
rtl/glu_pkg.sv
rtl/glu_div.sv
rtl/gcd_lcm_unit_top.sv
bench/gcd_lcm_checker.sv
bench/tb_gcd_lcm_unit_top.sv
